// ===== sv/htep_pkg.sv =====
// Package for the Huffman table encoder and packer: sizes, action codes and the stage struct.
`timescale 1ns / 1ps
package htep_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int CNT_W        = 3;
  localparam int PAD_W        = 3;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int ENTRY_W      = CODE_W + LEN_W;
  localparam int TABLE_DEPTH  = 1 << SYM_W;
  localparam int ACC_W        = PEND_W + LEN_LIMIT;
  localparam int TOT_W        = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // Item after the table read, waiting for the packer
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

// ===== sv/huffman_table_encoder_packer_top.sv =====
// Top level of the Huffman table encoder and byte packer.
`timescale 1ns / 1ps
// Input stream: tuser carries the action (load entry, encode symbol, flush);
// tdata carries symbol, code value and code length. Output stream: one
// transaction per result, tdata holds the byte and pad count, tuser the
// byte-valid flag, tlast marks the final result of an input item.
// Loads write the 256-entry code table RAM; encodes read it, then the packer
// appends the code to the pending bits and emits whole bytes MSB first.
// The first result of an item passes the lookup stage, the packer's working registers and the output register.
// Throughput: one input item per cycle, except an encode that yields k bytes
// (at most 4) or a flush holds the packer while it emits one byte per cycle,
// set by the single byte-wide output register, as long as the receiver is ready.
// Reset clears the pending bits and the per-entry written flags, so every
// table entry reads as having no code; no clearing pass is needed.
// When the receiver stalls, the output register holds its byte, the packer
// waits and s_tready falls once the lookup stage behind it is full.
module huffman_table_encoder_packer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // symbol[7:0], code_value[39:8], code_length[45:40], zeros
  input  logic [1:0]  s_tuser,  // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // out_byte[7:0], pad_count[10:8], zeros
  output logic        m_tuser,  // byte_valid
  output logic        m_tlast
);
  import htep_pkg::*;

  item_t             item;
  logic              xfer;
  logic              take;
  logic [BYTE_W-1:0] out_byte;
  logic [PAD_W-1:0]  pad_count;

  assign s_tready = !item.valid || xfer;
  assign take     = s_tvalid && s_tready;

  htep_table u_table (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .action      (s_tuser),
    .symbol      (s_tdata[7:0]),
    .code_value  (s_tdata[39:8]),
    .code_length (s_tdata[45:40]),
    .xfer        (xfer),
    .item        (item)
  );

  htep_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .xfer        (xfer),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_byte    (out_byte),
    .byte_valid  (m_tuser),
    .pad_count   (pad_count),
    .last_result (m_tlast)
  );

  assign m_tdata = {5'd0, pad_count, out_byte};

endmodule

// ===== sv/htep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module htep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/htep_table.sv =====
// Code table: loads entries into the RAM, looks up symbols and holds the looked-up item.
`timescale 1ns / 1ps
module htep_table (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [1:0]             action,
  input  logic [htep_pkg::SYM_W-1:0]  symbol,
  input  logic [htep_pkg::CODE_W-1:0] code_value,
  input  logic [htep_pkg::LEN_W-1:0]  code_length,
  input  logic                   xfer,
  output htep_pkg::item_t        item
);
  import htep_pkg::*;

  logic                 is_load;
  logic                 is_lookup;
  logic [LEN_W-1:0]     len_sat;
  logic [CODE_W-1:0]    code_mask;
  logic [ENTRY_W-1:0]   rdata;
  logic [TABLE_DEPTH-1:0] written;
  logic                 s1_valid;
  logic                 s1_flush;
  logic                 s1_ok;

  assign is_load   = take && (action == ACT_LOAD);
  assign is_lookup = take && ((action == ACT_ENCODE) || (action == ACT_FLUSH));

  always_comb begin
    len_sat = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
    if (len_sat >= LEN_W'(CODE_W)) begin
      code_mask = '1;
    end else begin
      code_mask = ~({CODE_W{1'b1}} << len_sat);
    end
  end

  htep_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (is_load),
    .waddr (symbol),
    .wdata ({len_sat, code_value & code_mask}),
    .re    (is_lookup),
    .raddr (symbol),
    .rdata (rdata)
  );

  // An entry never loaded since reset reads as length zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (is_load) begin
        written[symbol] <= 1'b1;
      end
      if (is_lookup) begin
        s1_valid <= 1'b1;
      end else if (xfer) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_lookup) begin
      s1_flush <= (action == ACT_FLUSH);
      s1_ok    <= written[symbol];
    end
  end

  always_comb begin
    item.valid = s1_valid;
    item.flush = s1_flush;
    item.code  = s1_ok ? rdata[CODE_W-1:0] : '0;
    item.len   = s1_ok ? rdata[ENTRY_W-1:CODE_W] : '0;
  end

endmodule

// ===== sv/htep_packer.sv =====
// Bit accumulator and byte emitter with the output register.
`timescale 1ns / 1ps
module htep_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  htep_pkg::item_t             item,
  output logic                        xfer,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [htep_pkg::BYTE_W-1:0] out_byte,
  output logic                        byte_valid,
  output logic [htep_pkg::PAD_W-1:0]  pad_count,
  output logic                        last_result
);
  import htep_pkg::*;

  logic              wk_busy;
  logic              wk_flush;
  logic [ACC_W-1:0]  wk_acc;
  logic [TOT_W-1:0]  wk_total;
  logic [BYTE_W-1:0] wk_fbyte;
  logic              wk_fvalid;
  logic [PAD_W-1:0]  wk_fpad;

  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;
  logic [PEND_W-1:0] pend_bits_next;
  logic [CNT_W-1:0]  pend_cnt_next;

  logic              emit;
  logic              fin;
  logic [CNT_W-1:0]  fin_cnt;
  logic [PEND_W-1:0] fin_bits;
  logic [PEND_W-1:0] fwd_bits;
  logic [CNT_W-1:0]  fwd_cnt;
  logic [ACC_W-1:0]  new_acc;
  logic [TOT_W-1:0]  new_total;
  logic [TOT_W-1:0]  emit_shift;
  logic [BYTE_W-1:0] emit_byte;
  logic [PAD_W-1:0]  new_pad;
  logic [BYTE_W-1:0] new_fbyte;

  assign emit = wk_busy && (!out_valid || out_ready);
  assign fin  = emit && (wk_flush || (wk_total < TOT_W'(2 * BYTE_W)));
  assign xfer = item.valid && (!wk_busy || fin);

  always_comb begin
    fin_cnt    = CNT_W'(wk_total - TOT_W'(BYTE_W));
    fin_bits   = wk_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << fin_cnt);
    // Forward the leftover bits of an item that finishes in this cycle
    if (fin && !wk_flush) begin
      fwd_bits = fin_bits;
      fwd_cnt  = fin_cnt;
    end else begin
      fwd_bits = pend_bits;
      fwd_cnt  = pend_cnt;
    end
    new_acc    = (ACC_W'(fwd_bits) << item.len) | ACC_W'(item.code);
    new_total  = TOT_W'(fwd_cnt) + TOT_W'(item.len);
    new_pad    = PAD_W'(4'd8 - {1'b0, fwd_cnt});
    new_fbyte  = {1'b0, fwd_bits} << new_pad;
    emit_shift = wk_total - TOT_W'(BYTE_W);
    emit_byte  = BYTE_W'(wk_acc >> emit_shift);
  end

  always_comb begin
    pend_bits_next = fwd_bits;
    pend_cnt_next  = fwd_cnt;
    if (xfer) begin
      if (item.flush) begin
        pend_bits_next = '0;
        pend_cnt_next  = '0;
      end else if ((item.len != '0) && (new_total < TOT_W'(BYTE_W))) begin
        pend_bits_next = PEND_W'(new_acc);
        pend_cnt_next  = CNT_W'(new_total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wk_busy   <= 1'b0;
      out_valid <= 1'b0;
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (xfer && (item.flush || (new_total >= TOT_W'(BYTE_W)))) begin
        wk_busy <= 1'b1;
      end else if (fin) begin
        wk_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= wk_flush ? wk_fbyte : emit_byte;
      byte_valid  <= wk_flush ? wk_fvalid : 1'b1;
      pad_count   <= wk_flush ? wk_fpad : '0;
      last_result <= fin;
    end
    if (xfer) begin
      wk_flush  <= item.flush;
      wk_acc    <= new_acc;
      wk_total  <= new_total;
      wk_fbyte  <= new_fbyte;
      wk_fvalid <= (fwd_cnt != '0);
      wk_fpad   <= new_pad;
    end else if (emit) begin
      wk_total  <= wk_total - TOT_W'(BYTE_W);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the Huffman table encoder and packer: random load/encode/flush traffic.
`timescale 1ns / 1ps
module tb_top;
  import htep_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int N_RANDOM = 80;

  typedef struct {
    logic [1:0]  action;
    logic [7:0]  sym;
    logic [31:0] value;
    logic [5:0]  len;
  } enc_item_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       byte_valid;
    logic [2:0] pad;
    logic       last;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  huffman_table_encoder_packer_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Shadow of the block state
  logic [31:0] code_tbl [256];
  logic [5:0]  len_tbl  [256];
  logic [6:0]  pend_bits;
  int unsigned pend_cnt;

  enc_item_t    stim_q [$];
  packed_byte_t expected_bytes [$];

  int n_total, n_accepted, n_loads, n_encodes, n_flushes, n_results;
  int n_mismatch;

  // Update the shadow state and queue the bytes this item produces
  task automatic pack_expected_bytes(input enc_item_t it);
    logic [63:0]  acc;
    logic [5:0]   clen;
    logic [31:0]  val;
    int unsigned  total;
    int unsigned  pad;
    packed_byte_t r;
    case (it.action)
      ACT_LOAD: begin
        clen = (it.len > LEN_LIMIT) ? 6'(LEN_LIMIT) : it.len;
        val  = it.value;
        if (clen < 32) val = val & 32'((64'd1 << clen) - 64'd1);
        code_tbl[it.sym] = val;
        len_tbl[it.sym]  = clen;
        n_loads++;
      end
      ACT_ENCODE: begin
        n_encodes++;
        clen = len_tbl[it.sym];
        if (clen != 0) begin
          acc   = (64'(pend_bits) << clen) | 64'(code_tbl[it.sym]);
          total = pend_cnt + clen;
          while (total >= 8) begin
            r.byte_val   = 8'(acc >> (total - 8));
            r.byte_valid = 1'b1;
            r.pad        = 3'd0;
            total        = total - 8;
            r.last       = (total < 8);
            expected_bytes.insert(expected_bytes.size(), r);
          end
          pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          pend_cnt  = total;
        end
      end
      ACT_FLUSH: begin
        n_flushes++;
        if (pend_cnt == 0) begin
          r = '{8'd0, 1'b0, 3'd0, 1'b1};
        end else begin
          pad = 8 - pend_cnt;
          r   = '{8'(16'(pend_bits) << pad), 1'b1, 3'(pad), 1'b1};
        end
        expected_bytes.insert(expected_bytes.size(), r);
        pend_bits = '0;
        pend_cnt  = 0;
      end
      default: ;  // unused action code: nothing happens
    endcase
  endtask

  task automatic add_item(input logic [1:0] act, input logic [7:0] sym,
                          input logic [31:0] value, input logic [5:0] len);
    enc_item_t it;
    it = '{act, sym, value, len};
    stim_q.insert(stim_q.size(), it);
    n_total++;
  endtask

  // Driver: bursts of transactions separated by random gaps
  enc_item_t drv_item;
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pack_expected_bytes(drv_item);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          drv_item = stim_q.pop_front();
          s_tdata  <= {2'b00, drv_item.len, drv_item.value, drv_item.sym};
          s_tuser  <= drv_item.action;
          s_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls follow a mode that changes every so often
  int stall_mode  = 0;
  int mode_cycles = 0;
  int pat_cnt     = 0;

  always @(posedge clk) begin
    packed_byte_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tuser, m_tdata[10:8], m_tlast};
        n_results++;
        if (expected_bytes.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected transaction: byte %h valid %b pad %0d last %b",
                     got.byte_val, got.byte_valid, got.pad, got.last);
        end else begin
          want = expected_bytes.pop_front();
          if (got != want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp byte %h valid %b pad %0d last %b, got %h %b %0d %b",
                       want.byte_val, want.byte_valid, want.pad, want.last,
                       got.byte_val, got.byte_valid, got.pad, got.last);
          end
        end
      end
      if (mode_cycles == 0) begin
        stall_mode  = $urandom_range(0, 3);
        mode_cycles = $urandom_range(20, 80);
      end
      mode_cycles--;
      pat_cnt++;
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 9) < 3);
        default: m_tready <= (pat_cnt % 3 == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit has_code [256];
    logic [7:0] loaded [$];
    logic [7:0] sym;
    logic [5:0] len;
    int counted, pick;

    for (int i = 0; i < 256; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = '0;
      has_code[i] = 1'b0;
    end
    pend_bits = '0;
    pend_cnt  = 0;

    // Directed: empty flush, codeless symbol, unused action, saturation, extremes
    add_item(ACT_FLUSH,  8'h00, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    add_item(ACT_UNUSED, 8'h3C, 32'h1234_5678, 6'd5);
    add_item(ACT_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
    add_item(ACT_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd1);   // upper bits dropped
    add_item(ACT_LOAD,   8'h55, 32'hA5A5_A5A5, 6'd63);  // saturates
    add_item(ACT_LOAD,   8'hAA, 32'h0000_0005, 6'd3);
    add_item(ACT_LOAD,   8'h01, 32'hDEAD_BEEF, 6'd0);
    add_item(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'hFF, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'h55, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'hAA, 32'h0, 6'd0);
    add_item(ACT_FLUSH,  8'h00, 32'h0, 6'd0);
    add_item(ACT_ENCODE, 8'h01, 32'h0, 6'd0);
    add_item(ACT_LOAD,   8'h80, 32'h0000_00AB, 6'd8);
    add_item(ACT_ENCODE, 8'h80, 32'h0, 6'd0);
    for (int i = 0; i < 7; i++) add_item(ACT_ENCODE, 8'h00, 32'h0, 6'd0);
    add_item(ACT_FLUSH,  8'h00, 32'h0, 6'd0);
    add_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    add_item(ACT_LOAD,   8'h7F, 32'h1234_5678, 6'd33);
    has_code[8'hFF] = 1; has_code[8'h00] = 1; has_code[8'h55] = 1;
    has_code[8'hAA] = 1; has_code[8'h80] = 1; has_code[8'h7F] = 1;
    loaded = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h80, 8'h7F};

    // Random: fill a table first, then mostly encodes of coded symbols
    counted = 0;
    while (counted < N_RANDOM) begin
      if (counted < 30) pick = 0;
      else pick = $urandom_range(1, 100);
      sym = 8'($urandom);
      if (pick <= 10) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = 6'd0;
        else if (pick < 14) len = 6'($urandom_range(1, 12));
        else if (pick < 18) len = 6'($urandom_range(13, 32));
        else                len = 6'($urandom_range(33, 63));
        add_item(ACT_LOAD, sym, $urandom, len);
        has_code[sym] = (len != 0);
        if (len != 0) loaded.insert(loaded.size(), sym);
        counted++;
      end else if (pick <= 75) begin
        sym = loaded[$urandom_range(0, loaded.size() - 1)];
        if (!has_code[sym]) sym = 8'($urandom);
        add_item(ACT_ENCODE, sym, $urandom, 6'($urandom));
        counted++;
      end else if (pick <= 85) begin
        add_item(ACT_ENCODE, sym, $urandom, 6'($urandom));
        counted++;
      end else if (pick <= 96) begin
        add_item(ACT_FLUSH, sym, $urandom, 6'($urandom));
        counted++;
      end else begin
        add_item(ACT_UNUSED, sym, $urandom, 6'($urandom));
      end
    end
    add_item(ACT_FLUSH, 8'h00, 32'h0, 6'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (n_accepted < n_total || expected_bytes.size() != 0);
    repeat (16) @(negedge clk);

    $display("covered %0d items: %0d table loads, %0d encodes, %0d flushes",
             n_total, n_loads, n_encodes, n_flushes);
    $display("%0d output bytes checked, %0d mismatches", n_results, n_mismatch);
    if (n_mismatch == 0 && expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/htep_pkg.sv
sv/htep_ram.sv
sv/htep_table.sv
sv/htep_packer.sv
sv/huffman_table_encoder_packer_top.sv
tb/tb_top.sv
